// ===== rtl/core/sm3_pkg.sv =====
// sm3_pkg: constants and round functions shared by the SM3 hash engine.
// No dependencies.
`timescale 1ns / 1ps
package sm3_pkg;

	localparam int WordW  = 32;
	localparam int QDepth = 4;

	localparam logic [31:0] T_LOW    = 32'h79cc4519;
	localparam logic [31:0] T_HIGH   = 32'h7a879d8a;
	localparam logic [31:0] PAD_WORD = 32'h80000000;

	localparam logic [31:0] IV [8] = '{
		32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
		32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
	};

	// queue entry: one word for the compressor, plus end-of-message flag
	typedef struct packed {
		logic [31:0] word;
		logic        fin;
	} qword_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

endpackage

// ===== rtl/core/sm3_front.sv =====
// sm3_front: accepts message words, inserts pad, zero fill and bit length.
// Depends on sm3_pkg.
`timescale 1ns / 1ps
module sm3_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        msg_word,
	input  logic [2:0]         valid_bytes,
	input  logic               last_word,
	input  logic               in_valid,
	output logic               in_stall,
	output sm3_pkg::qword_t    q_data,
	output logic               q_valid,
	input  logic               q_stall
);
	import sm3_pkg::*;

	typedef enum logic [2:0] {S_IN, S_PAD80, S_ZERO, S_LENHI, S_LENLO} st_t;

	st_t         st_q;
	logic [3:0]  cnt_q;
	logic [63:0] bits_q;
	logic [2:0]  v;
	logic [31:0] keep, lastw;
	logic        take;

	assign v = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
	always_comb begin
		unique case (v)
			3'd0:    keep = 32'h0;
			3'd1:    keep = 32'hff000000;
			3'd2:    keep = 32'hffff0000;
			3'd3:    keep = 32'hffffff00;
			default: keep = 32'hffffffff;
		endcase
	end
	assign lastw = (v == 3'd4) ? msg_word : ((msg_word & keep) | (PAD_WORD >> {v, 3'b000}));

	always_comb begin
		q_valid = 1'b1;
		q_data.fin = 1'b0;
		unique case (st_q)
			S_IN: begin
				q_valid = in_valid;
				q_data.word = last_word ? lastw : msg_word;
			end
			S_PAD80: q_data.word = PAD_WORD;
			S_ZERO:  q_data.word = '0;
			S_LENHI: q_data.word = bits_q[63:32];
			default: begin
				q_data.word = bits_q[31:0];
				q_data.fin = 1'b1;
			end
		endcase
	end
	assign in_stall = (st_q != S_IN) || q_stall;
	assign take = q_valid && !q_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IN;
			cnt_q <= '0;
			bits_q <= '0;
		end else if (take) begin
			cnt_q <= cnt_q + 4'd1;
			unique case (st_q)
				S_IN: begin
					if (last_word) begin
						bits_q <= bits_q + {58'd0, v, 3'b000};
						st_q <= (v == 3'd4) ? S_PAD80 : ((cnt_q == 4'd13) ? S_LENHI : S_ZERO);
					end else begin
						bits_q <= bits_q + 64'd32;
					end
				end
				S_PAD80, S_ZERO: st_q <= (cnt_q == 4'd13) ? S_LENHI : S_ZERO;
				S_LENHI: st_q <= S_LENLO;
				default: begin
					st_q <= S_IN;
					bits_q <= '0;
				end
			endcase
		end
	end
endmodule

// ===== rtl/core/sm3_queue.sv =====
// sm3_queue: small FIFO between front and compressor.
// Depends on sm3_pkg.
`timescale 1ns / 1ps
module sm3_queue #(
	parameter int Depth = sm3_pkg::QDepth
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sm3_pkg::qword_t wr_data,
	input  logic            wr_valid,
	output logic            wr_stall,
	output sm3_pkg::qword_t rd_data,
	output logic            rd_valid,
	input  logic            rd_stall
);
	import sm3_pkg::*;
	localparam int AW = $clog2(Depth);

	qword_t          mem_q [Depth];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     n_q;
	logic            wr, rd;

	assign wr_stall = (n_q == Depth[AW:0]);
	assign rd_valid = (n_q != '0);
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && !wr_stall;
	assign rd = rd_valid && !rd_stall;

	always_ff @(posedge clk) if (wr) mem_q[wp_q] <= wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			n_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			n_q <= n_q + {{AW{1'b0}}, wr} - {{AW{1'b0}}, rd};
		end
	end
endmodule

// ===== rtl/core/sm3_back.sv =====
// sm3_back: gathers 16-word blocks, runs 64 rounds one per cycle, emits digest.
// Depends on sm3_pkg.
`timescale 1ns / 1ps
module sm3_back (
	input  logic            clk,
	input  logic            arst_n,
	input  sm3_pkg::qword_t q_data,
	input  logic            q_valid,
	output logic            q_stall,
	output logic [31:0]     digest_word,
	output logic [2:0]      word_index,
	output logic            last_digest,
	output logic            out_valid,
	input  logic            out_stall
);
	import sm3_pkg::*;

	typedef enum logic [1:0] {S_LOAD, S_ROUND, S_FOLD, S_OUT} st_t;

	st_t         st_q;
	logic [31:0] w_q [16];   // sliding window of W[j..j+15]
	logic [31:0] v_q [8];
	logic [31:0] cv_q [8];
	logic [3:0]  cnt_q;
	logic [5:0]  rnd_q;
	logic        fin_q;
	logic [2:0]  oidx_q;

	logic [31:0] a12, ss1, ss2, ffv, ggv, tt1, tt2, wnew, tj;

	assign tj   = rotl((rnd_q < 6'd16) ? T_LOW : T_HIGH, rnd_q[4:0]);
	assign a12  = rotl(v_q[0], 5'd12);
	assign ss1  = rotl(a12 + v_q[4] + tj, 5'd7);
	assign ss2  = ss1 ^ a12;
	assign ffv  = (rnd_q < 6'd16) ? (v_q[0] ^ v_q[1] ^ v_q[2])
		: ((v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]));
	assign ggv  = (rnd_q < 6'd16) ? (v_q[4] ^ v_q[5] ^ v_q[6])
		: ((v_q[4] & v_q[5]) | (~v_q[4] & v_q[6]));
	assign tt1  = ffv + v_q[3] + ss2 + (w_q[0] ^ w_q[4]);
	assign tt2  = ggv + v_q[7] + ss1 + w_q[0];
	assign wnew = perm1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15))
		^ rotl(w_q[3], 5'd7) ^ w_q[10];

	assign q_stall     = (st_q != S_LOAD);
	assign out_valid   = (st_q == S_OUT);
	assign digest_word = cv_q[oidx_q];
	assign word_index  = oidx_q;
	assign last_digest = (oidx_q == 3'd7);

	always_ff @(posedge clk) begin
		if (st_q == S_LOAD && q_valid) w_q[cnt_q] <= q_data.word;
		if (st_q == S_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_LOAD;
			cnt_q <= '0;
			rnd_q <= '0;
			fin_q <= 1'b0;
			oidx_q <= '0;
			for (int i = 0; i < 8; i++) begin
				cv_q[i] <= IV[i];
				v_q[i] <= '0;
			end
		end else begin
			unique case (st_q)
				S_LOAD: if (q_valid) begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						fin_q <= q_data.fin;
						for (int i = 0; i < 8; i++) v_q[i] <= cv_q[i];
						st_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					v_q[0] <= tt1;
					v_q[1] <= v_q[0];
					v_q[2] <= rotl(v_q[1], 5'd9);
					v_q[3] <= v_q[2];
					v_q[4] <= perm0(tt2);
					v_q[5] <= v_q[4];
					v_q[6] <= rotl(v_q[5], 5'd19);
					v_q[7] <= v_q[6];
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) st_q <= S_FOLD;
				end
				S_FOLD: begin
					for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] ^ v_q[i];
					st_q <= fin_q ? S_OUT : S_LOAD;
				end
				default: if (!out_stall) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						for (int i = 0; i < 8; i++) cv_q[i] <= IV[i];
						st_q <= S_LOAD;
					end
				end
			endcase
		end
	end
endmodule

// ===== rtl/core/sm3_hash_engine.sv =====
// sm3_hash_engine: top level of the SM3 hash engine.
// Depends on sm3_pkg, sm3_front, sm3_queue, sm3_back.
//
// Usage: message words enter on in_* (msg_word, valid_bytes, last_word),
// big-endian, first byte in bits 31..24. Only the word with last_word set may
// carry 0..3 valid bytes; an empty message is a last word with zero bytes.
// After the last word the eight digest words leave on out_* in order,
// word_index 0..7, last_digest on word 7.
// Each 16-word block is loaded, run through 64 rounds (one round per cycle
// in the compressor) and folded into the chaining value; the front pads
// while the compressor works, through a 4-entry queue. After the last word
// the front pads, each remaining block is compressed, and the digest then
// leaves at one word per cycle while out_stall is low.
// Reset restores the initial value and clears all counters. A stalled output
// holds its word; the compressor waits, and input backs up through the queue.
`timescale 1ns / 1ps
module sm3_hash_engine #(
	parameter int QueueDepth = sm3_pkg::QDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] msg_word,
	input  logic [2:0]  valid_bytes,
	input  logic        last_word,
	input  logic        in_valid,
	output logic        in_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_digest,
	output logic        out_valid,
	input  logic        out_stall
);
	import sm3_pkg::*;

	qword_t f_data, b_data;
	logic   f_valid, f_stall, b_valid, b_stall;

	sm3_front u_front (
		.clk, .arst_n, .msg_word, .valid_bytes, .last_word, .in_valid, .in_stall,
		.q_data(f_data), .q_valid(f_valid), .q_stall(f_stall)
	);

	sm3_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n, .wr_data(f_data), .wr_valid(f_valid), .wr_stall(f_stall),
		.rd_data(b_data), .rd_valid(b_valid), .rd_stall(b_stall)
	);

	sm3_back u_back (
		.clk, .arst_n, .q_data(b_data), .q_valid(b_valid), .q_stall(b_stall),
		.digest_word, .word_index, .last_digest, .out_valid, .out_stall
	);

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_digest == (word_index == 3'd7)))
		else $error("last_digest out of step with word_index");

	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_digest) |=>
		(out_valid && word_index == $past(word_index) + 3'd1))
		else $error("digest words not consecutive");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(digest_word))
		else $error("digest changed under stall");

endmodule
